// ----- rtl/upd_pkg.sv -----
`timescale 1ns / 1ps

package upd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_PCT = 8'h25;
   localparam logic [7:0] CHAR_0   = 8'h30;
   localparam logic [7:0] CHAR_9   = 8'h39;
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_F   = 8'h46;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       was_escape;
      logic       out_last;
   } rsp_type;

   // one queue entry holds every beat that a single input byte produces
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
      logic                         esc;
      logic                         last;
   } entry_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_A) && (c <= CHAR_F));
   endfunction

   // 'A'..'F' have low nibble 1..6, so adding 9 gives 10..15
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      if (c <= CHAR_9) begin
         hex_val = c[3:0];
      end else begin
         hex_val = 4'(c[3:0] + 4'd9);
      end
   endfunction

endpackage

// ----- rtl/upd_front.sv -----
`timescale 1ns / 1ps

module upd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  upd_pkg::req_type   req_payload,
   input  logic               queue_full,
   output logic               push,
   output upd_pkg::entry_type push_entry
);
   import upd_pkg::*;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_PCT   = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       b_hex;
   logic       b_opens;
   entry_type  entry;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b_hex     = is_hex(req_payload.in_byte);
   // a '%' on the last byte of a string cannot open an escape
   assign b_opens   = (req_payload.in_byte == CHAR_PCT) && !req_payload.in_last;

   always_comb begin
      entry      = '0;
      entry.last = req_payload.in_last;
      phase_in   = phase_ff;
      held_in    = held_ff;
      unique case (phase_ff)
         PHASE_PCT: begin
            if (b_hex && !req_payload.in_last) begin
               phase_in = PHASE_DIGIT;
               held_in  = req_payload.in_byte;
            end else begin
               entry.bytes[2'd0] = CHAR_PCT;
               if (b_opens) begin
                  phase_in    = PHASE_PCT;
                  entry.count = 2'd1;
               end else begin
                  phase_in          = PHASE_IDLE;
                  entry.bytes[2'd1] = req_payload.in_byte;
                  entry.count       = 2'd2;
               end
            end
         end
         PHASE_DIGIT: begin
            if (b_hex) begin
               phase_in          = PHASE_IDLE;
               entry.bytes[2'd0] = {hex_val(held_ff), hex_val(req_payload.in_byte)};
               entry.esc         = 1'b1;
               entry.count       = 2'd1;
            end else begin
               entry.bytes[2'd0] = CHAR_PCT;
               entry.bytes[2'd1] = held_ff;
               if (b_opens) begin
                  phase_in    = PHASE_PCT;
                  entry.count = 2'd2;
               end else begin
                  phase_in          = PHASE_IDLE;
                  entry.bytes[2'd2] = req_payload.in_byte;
                  entry.count       = 2'd3;
               end
            end
         end
         default: begin
            if (b_opens) begin
               phase_in = PHASE_PCT;
            end else begin
               phase_in          = PHASE_IDLE;
               entry.bytes[2'd0] = req_payload.in_byte;
               entry.count       = 2'd1;
            end
         end
      endcase
   end

   assign push       = accept && (entry.count != 2'd0);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_DIGIT |-> is_hex(held_ff))
      else $error("digit held without a valid hex character");

   assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PHASE_DIGIT) && b_hex |-> push && push_entry.esc)
      else $error("completed escape not queued as a decoded beat");
`endif

endmodule

// ----- rtl/upd_queue.sv -----
`timescale 1ns / 1ps

module upd_queue #(
   parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  upd_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               head_valid,
   output upd_pkg::entry_type head_entry,
   output logic               full
);
   import upd_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue occupancy did not follow a push");
`endif

endmodule

// ----- rtl/upd_back.sv -----
`timescale 1ns / 1ps

module upd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  upd_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output upd_pkg::rsp_type   rsp_payload
);
   import upd_pkg::*;

   logic       rsp_valid_ff;
   rsp_type    rsp_payload_ff, rsp_payload_in;
   logic [1:0] beat_ff, beat_in;
   logic       load;
   logic       take;
   logic       final_beat;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign take       = head_valid && load;
   assign final_beat = (beat_ff == 2'(head_entry.count - 2'd1));
   assign pop        = take && final_beat;

   always_comb begin
      rsp_payload_in.out_byte   = head_entry.bytes[beat_ff];
      rsp_payload_in.was_escape = head_entry.esc;
      rsp_payload_in.out_last   = head_entry.last && final_beat;
      beat_in = beat_ff;
      if (take) begin
         beat_in = final_beat ? 2'd0 : 2'(beat_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
      end else begin
         beat_ff <= beat_in;
         if (load) begin
            rsp_valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_entry.count != 2'd0) && (beat_ff < head_entry.count))
      else $error("beat index outside the head entry");

   assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> beat_ff == 2'd0)
      else $error("beat index left over with an empty queue");
`endif

endmodule

// ----- rtl/url_percent_decoder.sv -----
`timescale 1ns / 1ps
// path: the first beat of an input byte passes through the entry queue and the rsp output register
// throughput: one byte per cycle while each byte yields at most one beat and rsp is not stalled; a byte
//   that closes a broken escape yields one to three beats, which leave the single output port
//   one after another, the entry queue absorbing the difference
// reset: synchronous, active high; clears the escape phase, empties the queue, drops rsp_valid
module url_percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  upd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output upd_pkg::rsp_type rsp_payload
);
   import upd_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;
   logic      queue_full;

   upd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   upd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import upd_pkg::*;

   typedef enum logic [1:0] {PH_NONE, PH_PCT, PH_DIGIT} esc_phase_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // predictor state
   esc_phase_type esc_phase   = PH_NONE;
   logic [7:0]    first_digit = 8'h00;
   rsp_type       pending_chars[$];

   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   int stall_left    = 0;
   int fail_count    = 0;
   int bytes_sent    = 0;
   int beats_checked = 0;
   int escape_beats  = 0;

   url_percent_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_upper_hex(input logic [7:0] c);
      return (c inside {[CHAR_0:CHAR_9], [CHAR_A:CHAR_F]});
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c <= CHAR_9) begin
         return 4'(c - CHAR_0);
      end
      return 4'(c - CHAR_A + 8'd10);
   endfunction

   function automatic logic [7:0] random_hex_char();
      int unsigned r;
      r = $urandom_range(0, 15);
      return (r < 10) ? 8'(CHAR_0 + r) : 8'(CHAR_A + r - 10);
   endfunction

   task automatic push_char(input logic [7:0] b, input logic esc, input logic l);
      pending_chars.push_back(rsp_type'{out_byte: b, was_escape: esc, out_last: l});
   endtask

   // a byte seen with nothing pending: '%' opens an escape unless it ends the string
   task automatic take_plain(input logic [7:0] b, input logic l);
      if (b == CHAR_PCT && !l) begin
         esc_phase = PH_PCT;
      end else begin
         esc_phase = PH_NONE;
         push_char(b, 1'b0, l);
      end
   endtask

   task automatic predict_chars(input logic [7:0] b, input logic l);
      case (esc_phase)
         PH_PCT: begin
            if (is_upper_hex(b) && !l) begin
               first_digit = b;
               esc_phase   = PH_DIGIT;
            end else begin
               push_char(CHAR_PCT, 1'b0, 1'b0);
               take_plain(b, l);
            end
         end
         PH_DIGIT: begin
            if (is_upper_hex(b)) begin
               esc_phase = PH_NONE;
               push_char({nibble_of(first_digit), nibble_of(b)}, 1'b1, l);
            end else begin
               push_char(CHAR_PCT, 1'b0, 1'b0);
               push_char(first_digit, 1'b0, 1'b0);
               take_plain(b, l);
            end
         end
         default: begin
            take_plain(b, l);
         end
      endcase
   endtask

   task automatic send_char(input logic [7:0] b, input logic l);
      if (req_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_byte: b, in_last: l};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_chars(b, l);
      bytes_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic test_valid_escapes();
      // decoded zero, top value, and an escape closed by the last byte
      send_string("%00%FF");
      send_string("%9A");
   endtask

   task automatic test_broken_escapes();
      // lower case, bad second digit, and '%' right after '%'
      send_string("%f%4g%%41");
   endtask

   task automatic test_cut_by_end();
      send_string("%4");
      send_string("%");
      send_string("%4?");
   endtask

   task automatic test_plain_bytes();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("?", 1'b1);
   endtask

   task automatic test_pressure_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed escapes with random digits, some noise and broken ones
   task automatic test_random_strings(input int count);
      logic [7:0]  chars[$];
      int unsigned r;
      int          stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         chars.delete();
         repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               chars.push_back(CHAR_PCT);
               chars.push_back(random_hex_char());
               chars.push_back(random_hex_char());
            end else if (r < 75) begin
               chars.push_back(8'($urandom_range(0, 255)));
            end else if (r < 85) begin
               chars.push_back(CHAR_PCT);
            end else if (r < 93) begin
               chars.push_back(random_hex_char());
            end else begin
               chars.push_back(8'($urandom_range("a", "f")));
            end
         end
         for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], i == chars.size() - 1);
         end
      end
   endtask

   // result side stall in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 17);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (pending_chars.size() == 0) begin
            $error("unexpected beat: out_byte %h", rsp_payload.out_byte);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (want.was_escape) escape_beats++;
            if (rsp_payload.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_payload.out_byte);
               fail_count++;
            end
            if (rsp_payload.was_escape !== want.was_escape) begin
               $error("was_escape: expected %b, got %b", want.was_escape,
                      rsp_payload.was_escape);
               fail_count++;
            end
            if (rsp_payload.out_last !== want.out_last) begin
               $error("out_last: expected %b, got %b", want.out_last, rsp_payload.out_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_valid_escapes();
      test_broken_escapes();
      test_cut_by_end();
      test_plain_bytes();

      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      test_random_strings(150);
      test_pressure_pause();
      test_random_strings(100);

      // no idling on either side from here on
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      test_random_strings(150);

      req_valid <= 1'b0;
      waited = 0;
      while (pending_chars.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_chars.size() != 0) begin
         $error("%0d expected beats never arrived", pending_chars.size());
         fail_count++;
      end
      repeat (10) @(posedge clock);

      $display("sent %0d bytes in strings with valid, broken and truncated escapes",
               bytes_sent);
      $display("checked %0d output beats, %0d of them decoded escapes",
               beats_checked, escape_beats);
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
test/testbench.sv
